### hdl/ebcc_pkg.sv
package ebcc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [ByteW-1:0] CrcPoly = 8'h9b;
  localparam logic [ByteW-1:0] CrcInit = 8'h00;

  localparam logic [ByteW-1:0] SyncCodeRst = 8'haa;
  localparam logic [ByteW-1:0] EscCodeRst = 8'ha9;
  localparam logic [ByteW-1:0] SyncSubRst = 8'h01;
  localparam logic [ByteW-1:0] EscSubRst = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DECODE_MODE = 3'd0,
    CFG_SYNC_CODE   = 3'd1,
    CFG_ESC_CODE    = 3'd2,
    CFG_SYNC_SUB    = 3'd3,
    CFG_ESC_SUB     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic             decode_mode;
    logic [ByteW-1:0] sync_code;
    logic [ByteW-1:0] escape_code;
    logic [ByteW-1:0] sync_substitute;
    logic [ByteW-1:0] escape_substitute;
  } cfg_t;

  // CRC state shifted through the polynomial eight times, MSB first
  function automatic logic [ByteW-1:0] crc_shift(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] v;
    v = c;
    for (int i = 0; i < ByteW; i++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

### hdl/ebcc_cfg.sv
module ebcc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ebcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ebcc_pkg::ByteW-1:0]   cfg_data_i,
  output ebcc_pkg::cfg_t               cfg_o
);

  ebcc_pkg::cfg_t cfg_q;
  ebcc_pkg::cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (ebcc_pkg::cfg_reg_e'(cfg_index_i))
        ebcc_pkg::CFG_DECODE_MODE: cfg_d.decode_mode = cfg_data_i[0];
        ebcc_pkg::CFG_SYNC_CODE:   cfg_d.sync_code = cfg_data_i;
        ebcc_pkg::CFG_ESC_CODE:    cfg_d.escape_code = cfg_data_i;
        ebcc_pkg::CFG_SYNC_SUB:    cfg_d.sync_substitute = cfg_data_i;
        ebcc_pkg::CFG_ESC_SUB:     cfg_d.escape_substitute = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decode_mode       <= 1'b0;
      cfg_q.sync_code         <= ebcc_pkg::SyncCodeRst;
      cfg_q.escape_code       <= ebcc_pkg::EscCodeRst;
      cfg_q.sync_substitute   <= ebcc_pkg::SyncSubRst;
      cfg_q.escape_substitute <= ebcc_pkg::EscSubRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/ebcc_core.sv
module ebcc_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ebcc_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ebcc_pkg::ByteW-1:0] in_byte_i,
  input  logic                       in_first_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ebcc_pkg::ByteW-1:0] out_byte_o,
  output logic                       out_byte_valid_o,
  output logic [ebcc_pkg::ByteW-1:0] out_crc_o,
  output logic                       out_last_o
);

  // input stage
  logic                       in_valid_q;
  logic [ebcc_pkg::ByteW-1:0] in_byte_q;
  logic                       in_first_q;
  logic                       phase_q;

  // running state
  logic [ebcc_pkg::ByteW-1:0] crc_q, crc_d;
  logic                       pend_q, pend_d;

  // result stage
  logic                       out_valid_q;
  logic [ebcc_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic                       out_bv_q, out_bv_d;
  logic [ebcc_pkg::ByteW-1:0] out_crc_q;
  logic                       out_last_q, out_last_d;

  logic                       is_sync, is_code, two_beats, fire, restart;
  logic [ebcc_pkg::ByteW-1:0] crc_base, feed_byte;
  logic                       pend_base;

  assign is_sync   = (in_byte_q == cfg_i.sync_code);
  assign is_code   = is_sync || (in_byte_q == cfg_i.escape_code);
  assign two_beats = !cfg_i.decode_mode && is_code;
  assign restart   = in_first_q && !phase_q;
  assign crc_base  = restart ? ebcc_pkg::CrcInit : crc_q;
  assign pend_base = restart ? 1'b0 : pend_q;
  assign fire      = in_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    out_bv_d   = 1'b1;
    out_last_d = !two_beats || phase_q;
    pend_d     = pend_base;
    out_byte_d = in_byte_q;
    feed_byte  = in_byte_q;
    if (!cfg_i.decode_mode) begin
      if (two_beats) begin
        if (phase_q) begin
          out_byte_d = is_sync ? cfg_i.sync_substitute : cfg_i.escape_substitute;
        end else begin
          out_byte_d = cfg_i.escape_code;
        end
      end
      feed_byte = out_byte_d;
    end else if (is_code) begin
      pend_d     = 1'b1;
      out_bv_d   = 1'b0;
      out_byte_d = '0;
    end else if (pend_base) begin
      pend_d     = 1'b0;
      out_byte_d = (in_byte_q == cfg_i.sync_substitute) ? cfg_i.sync_code
                                                         : cfg_i.escape_code;
    end
    crc_d = ebcc_pkg::crc_shift(crc_base) ^ feed_byte;
  end

  assign in_ready_o = !in_valid_q || (fire && out_last_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      crc_q       <= ebcc_pkg::CrcInit;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire && out_last_d) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        phase_q     <= !out_last_d;
        crc_q       <= crc_d;
        pend_q      <= pend_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q  <= in_byte_i;
      in_first_q <= in_first_i;
    end
    if (fire) begin
      out_byte_q <= out_byte_d;
      out_bv_q   <= out_bv_d;
      out_crc_q  <= crc_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign out_byte_valid_o = out_bv_q;
  assign out_crc_o        = out_crc_q;
  assign out_last_o       = out_last_q;

endmodule

### hdl/ebus_escape_crc_codec.sv
// An accepted input beat is held in the input stage and its result is registered in
// the result stage. Throughput: one input beat per cycle while the result side does
// not stall; an encoded sync or escape byte yields two result beats and holds the
// input stage until the second one is produced. Reset (rst_ni low, asynchronous): CRC
// and pending escape cleared, configuration back to its defaults, both stages emptied.
module ebus_escape_crc_codec (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ebcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ebcc_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] data_byte
  input  logic                         s_axis_tuser_i,  // [0] first
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [15:0]                  m_axis_tdata_o,  // [7:0] out_byte, [15:8] crc_value
  output logic                         m_axis_tuser_o,  // [0] byte_valid
  output logic                         m_axis_tlast_o
);

  ebcc_pkg::cfg_t cfg;

  ebcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ebcc_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .in_byte_i        (s_axis_tdata_i),
    .in_first_i       (s_axis_tuser_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_byte_o       (m_axis_tdata_o[7:0]),
    .out_byte_valid_o (m_axis_tuser_o),
    .out_crc_o        (m_axis_tdata_o[15:8]),
    .out_last_o       (m_axis_tlast_o)
  );

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ebcc_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned HoldOffLen = 300;
  localparam int unsigned RandPhases = 9;
  localparam int unsigned ItemsPerPhase = 72;

  class codec_scoreboard;
    typedef struct {
      logic [ByteW-1:0] out_byte;
      logic             byte_valid;
      logic [ByteW-1:0] crc_value;
      logic             last;
    } out_beat_t;

    cfg_t             cfg;
    logic [ByteW-1:0] crc;
    logic             esc_pending;
    out_beat_t        expected_q[$];
    int               errors;

    function new();
      cfg.decode_mode       = 1'b0;
      cfg.sync_code         = SyncCodeRst;
      cfg.escape_code       = EscCodeRst;
      cfg.sync_substitute   = SyncSubRst;
      cfg.escape_substitute = EscSubRst;
      crc         = CrcInit;
      esc_pending = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        CFG_DECODE_MODE: cfg.decode_mode = val[0];
        CFG_SYNC_CODE:   cfg.sync_code = val;
        CFG_ESC_CODE:    cfg.escape_code = val;
        CFG_SYNC_SUB:    cfg.sync_substitute = val;
        CFG_ESC_SUB:     cfg.escape_substitute = val;
        default: ;
      endcase
    endfunction

    // MSB-first division by the polynomial, one bit per pass
    function logic [ByteW-1:0] crc_next(logic [ByteW-1:0] c, logic [ByteW-1:0] b);
      logic [ByteW-1:0] v;
      v = c;
      repeat (ByteW) v = (v << 1) ^ (v[ByteW-1] ? CrcPoly : '0);
      return v ^ b;
    endfunction

    function void emit(logic [ByteW-1:0] crc_byte, logic [ByteW-1:0] ob, logic vld,
                       logic lst);
      out_beat_t e;
      crc = crc_next(crc, crc_byte);
      e.out_byte   = ob;
      e.byte_valid = vld;
      e.crc_value  = crc;
      e.last       = lst;
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void note_input(logic [ByteW-1:0] b, logic first);
      logic [ByteW-1:0] sub;
      if (first) begin
        crc = CrcInit;
        esc_pending = 1'b0;
      end
      if (!cfg.decode_mode) begin
        if (b == cfg.sync_code || b == cfg.escape_code) begin
          sub = (b == cfg.sync_code) ? cfg.sync_substitute : cfg.escape_substitute;
          emit(cfg.escape_code, cfg.escape_code, 1'b1, 1'b0);
          emit(sub, sub, 1'b1, 1'b1);
        end else begin
          emit(b, b, 1'b1, 1'b1);
        end
      end else if (b == cfg.sync_code || b == cfg.escape_code) begin
        esc_pending = 1'b1;
        emit(b, 8'h00, 1'b0, 1'b1);
      end else if (esc_pending) begin
        esc_pending = 1'b0;
        emit(b, (b == cfg.sync_substitute) ? cfg.sync_code : cfg.escape_code, 1'b1, 1'b1);
      end else begin
        emit(b, b, 1'b1, 1'b1);
      end
    endfunction

    function void check_field(string name, logic [ByteW-1:0] exp, logic [ByteW-1:0] act);
      if (act !== exp) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic [15:0] tdata, logic tuser, logic tlast);
      out_beat_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: tdata %0h tuser %0b tlast %0b",
               tdata, tuser, tlast);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      check_field("out_byte", e.out_byte, tdata[7:0]);
      check_field("crc_value", e.crc_value, tdata[15:8]);
      check_field("byte_valid", {7'b0, e.byte_valid}, {7'b0, tuser});
      check_field("last", {7'b0, e.last}, {7'b0, tlast});
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]   cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [15:0]        m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  int unsigned        sender_idle_pct = 9;
  int unsigned        receiver_idle_pct = 86;
  bit                 hold_off_req = 1'b0;
  int unsigned        idle_cycles = 0;

  codec_scoreboard    codec_sb = new();

  ebus_escape_crc_codec DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      codec_sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HoldOffLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    codec_sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // leaves tvalid high so back-to-back beats need no toggle
  task automatic send_byte(logic [7:0] b, logic first);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tuser  = first;
    do @(posedge clk); while (!s_tready);
    codec_sb.note_input(b, first);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (codec_sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic write_all(logic mode, logic [7:0] sc, logic [7:0] ec, logic [7:0] ss,
                           logic [7:0] es);
    write_reg(CFG_DECODE_MODE, {7'b0, mode});
    write_reg(CFG_SYNC_CODE, sc);
    write_reg(CFG_ESC_CODE, ec);
    write_reg(CFG_SYNC_SUB, ss);
    write_reg(CFG_ESC_SUB, es);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned n;
    int unsigned r;
    logic        first;
    logic [7:0]  follow;
    n = 0;
    while (n < count) begin
      first = ($urandom_range(99) < 4);
      r = $urandom_range(99);
      if (codec_sb.cfg.decode_mode) begin
        if (r < 35) begin
          send_byte($urandom_range(1) ? codec_sb.cfg.sync_code : codec_sb.cfg.escape_code,
                    first);
          n++;
          if ($urandom_range(99) < 80) begin
            case ($urandom_range(2))
              0: follow = codec_sb.cfg.sync_substitute;
              1: follow = codec_sb.cfg.escape_substitute;
              default: follow = 8'($urandom_range(255));
            endcase
            send_byte(follow, 1'b0);
            n++;
          end
        end else begin
          send_byte(8'($urandom_range(255)), first);
          n++;
        end
      end else if (r < 40) begin
        send_byte($urandom_range(1) ? codec_sb.cfg.sync_code : codec_sb.cfg.escape_code,
                  first);
        n++;
      end else begin
        send_byte(8'($urandom_range(255)), first);
        n++;
      end
    end
  endtask

  initial begin
    logic [7:0] sc;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // reset defaults, encode
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'ha9, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h55, 1'b0);
    drain();

    // switch to decode mid-stream, CRC carries over
    write_reg(CFG_DECODE_MODE, 8'h01);
    send_byte(8'ha9, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'haa, 1'b0);
    drain();

    // encode with equal sync and escape codes; pending escape stays set
    write_all(1'b0, 8'hff, 8'hff, 8'h00, 8'hff);
    for (int idx = int'(CFG_ESC_SUB) + 1; idx < 2 ** CfgIdxW; idx++) begin
      write_reg(CfgIdxW'(idx), 8'hff);
    end
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    drain();

    write_all(1'b1, 8'h00, 8'hff, 8'h80, 8'h00);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h42, 1'b1);
    drain();

    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph / 3)
        0: begin
          sender_idle_pct = 9;
          receiver_idle_pct = 86;
        end
        1: begin
          sender_idle_pct = 86;
          receiver_idle_pct = 9;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      sc = pick_code();
      write_all(ph[0], sc, ($urandom_range(99) < 15) ? sc : pick_code(), pick_code(),
                pick_code());
      if (ph == 6) hold_off_req = 1'b1;
      run_random(ItemsPerPhase);
      drain();
    end

    repeat (10) @(posedge clk);
    if (codec_sb.errors == 0 && codec_sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
